/* hw/rtl/nlfsr_pkg.sv */
// nlfsr_pkg: shared constants and types of the nlfsr period tester
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package nlfsr_pkg;

   // register and function geometry
   localparam int REG_WIDTH = 16;
   localparam int NUM_VARS  = 7;
   localparam int TT_SIZE   = 1 << NUM_VARS;
   localparam int ANF_W     = 64;
   localparam int STAGE_W   = 3;

   // tap positions of the two runs
   localparam int TAP_MSB  = 15;
   localparam int TAP_A1   = 11;
   localparam int TAP_A2   = 2;
   localparam int TAP_A3   = 0;
   localparam int TAP_B1   = 13;
   localparam int TAP_B2   = 12;
   localparam int TAP_B3   = 10;

   // configuration registers
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS  = 2'd1;
   localparam logic [REG_WIDTH-1:0] SEED_RESET = 16'd43767;
   localparam logic [REG_WIDTH-1:0] MAX_RESET  = 16'd65535;

   typedef logic [REG_WIDTH-1:0] word_type;
   typedef logic [TT_SIZE-1:0]   table_type;

   // command from the sequencer to the step unit
   typedef struct packed {
      logic start;
      logic tap_alt;
   } run_cmd_type;

   // end-of-run status from the step unit
   typedef struct packed {
      logic     done;
      logic     returned;
      word_type period;
   } run_stat_type;

endpackage

`default_nettype wire

/* hw/rtl/nlfsr_if.sv */
// nlfsr_if: valid/ready channels of the nlfsr period tester
// depends on nlfsr_pkg for field widths
`default_nettype none

interface nlfsr_req_if import nlfsr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ANF_W-1:0] anf_low;
   logic [ANF_W-1:0] anf_high;
   modport source (output valid, output anf_low, output anf_high, input ready);
   modport sink   (input valid, input anf_low, input anf_high, output ready);
endinterface

interface nlfsr_rsp_if import nlfsr_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type first_period;
   logic     first_returned;
   logic     second_tried;
   word_type second_period;
   logic     second_returned;
   modport source (output valid, output first_period, output first_returned,
                   output second_tried, output second_period, output second_returned,
                   input ready);
   modport sink   (input valid, input first_period, input first_returned,
                   input second_tried, input second_period, input second_returned,
                   output ready);
endinterface

interface nlfsr_csr_if import nlfsr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   word_type             data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nlfsr_anf_xform.sv */
// nlfsr_anf_xform: turns 128 anf coefficients into the truth table of f
// one butterfly stage of the binary moebius transform per cycle; uses nlfsr_pkg
`default_nettype none

module nlfsr_anf_xform import nlfsr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic [ANF_W-1:0] anf_low,
   input  wire logic [ANF_W-1:0] anf_high,
   output logic                  done,
   output table_type             truth
);

   logic               busy_ff, busy_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   table_type          tt_ff, tt_in;
   table_type          butterfly;
   logic               last_stage;

   assign last_stage = (stage_ff == STAGE_W'(NUM_VARS - 1));
   assign done       = busy_ff && last_stage;
   assign truth      = tt_ff;

   // one stage: entries with the stage bit set take the xor of their partner
   always_comb begin
      logic [NUM_VARS-1:0] mb;
      for (int m = 0; m < TT_SIZE; m++) begin
         mb = NUM_VARS'(m);
         butterfly[mb] = tt_ff[mb];
         for (int k = 0; k < NUM_VARS; k++) begin
            if (stage_ff == STAGE_W'(k) && mb[k]) begin
               butterfly[mb] = tt_ff[mb] ^ tt_ff[mb ^ NUM_VARS'(1 << k)];
            end
         end
      end
   end

   // stage sequencing
   always_comb begin
      busy_in  = busy_ff;
      stage_in = stage_ff;
      tt_in    = tt_ff;
      if (load) begin
         busy_in  = 1'b1;
         stage_in = '0;
         tt_in    = {anf_high, anf_low};
      end else if (busy_ff) begin
         tt_in    = butterfly;
         stage_in = stage_ff + STAGE_W'(1);
         if (last_stage) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         stage_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         stage_ff <= stage_in;
      end
      tt_ff <= tt_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/nlfsr_step_unit.sv */
// nlfsr_step_unit: the shared shift-register step unit, one step per cycle
// counts steps until the seed recurs or the cap is hit; uses nlfsr_pkg
`default_nettype none

module nlfsr_step_unit import nlfsr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire run_cmd_type cmd,
   input  wire word_type    seed,
   input  wire word_type    cap,
   input  wire table_type   truth,
   output run_stat_type     stat
);

   logic     busy_ff, busy_in;
   logic     tap_ff, tap_in;
   word_type state_ff, state_in;
   word_type count_ff, count_in;
   logic     taps, fbit, hit, at_cap;
   word_type state_nxt;

   // feedback bit and next register value
   always_comb begin
      if (tap_ff) begin
         taps = state_ff[TAP_B1] ^ state_ff[TAP_B2] ^ state_ff[TAP_B3];
      end else begin
         taps = state_ff[TAP_A1] ^ state_ff[TAP_A2] ^ state_ff[TAP_A3];
      end
      fbit      = 1'b1 ^ state_ff[TAP_MSB] ^ taps ^ truth[state_ff[NUM_VARS-1:0]];
      state_nxt = {state_ff[REG_WIDTH-2:0], fbit};
   end

   assign hit    = (state_nxt == seed);
   assign at_cap = (count_ff == cap);

   assign stat.done     = busy_ff && (hit || at_cap);
   assign stat.returned = hit;
   assign stat.period   = count_ff;

   // run control
   always_comb begin
      busy_in  = busy_ff;
      tap_in   = tap_ff;
      state_in = state_ff;
      count_in = count_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         tap_in   = cmd.tap_alt;
         state_in = seed;
         count_in = word_type'(1);
      end else if (busy_ff) begin
         if (hit || at_cap) begin
            busy_in = 1'b0;
         end else begin
            state_in = state_nxt;
            count_in = count_ff + word_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      tap_ff   <= tap_in;
      state_ff <= state_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/nlfsr_period_tester.sv */
// nlfsr_period_tester: top level, sequencer, configuration registers, result register
// depends on nlfsr_pkg, nlfsr_if, nlfsr_anf_xform and nlfsr_step_unit
//
// Takes one function (128 anf coefficients) at a time. A transfer on req is
// followed by the truth-table transform, then the first run of the
// 16-bit register at one step per cycle (P1 steps, P1 = period found or the
// cap max_steps), then, only when P1 equals the cap, a second run of P2 steps,
// then the load of the result register. The single step unit serves both runs
// one after the other. req is not ready while an item is in work; a finished
// result waits in its own register, so the next item can be taken before the
// result is transferred. An item that finishes while that register is still
// full holds in its finish state until the result is transferred. A max_steps
// of 0 acts as 1. Configuration is read live during a run, so the user must
// write csr only while no item is in work and no result is waiting; the block
// itself does not enforce it. seed_value resets to 43767, max_steps to 65535.
`default_nettype none

module nlfsr_period_tester import nlfsr_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   nlfsr_req_if.sink   req_ch,
   nlfsr_rsp_if.source rsp_ch,
   nlfsr_csr_if.sink   csr_ch
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_XFORM  = 3'd1;
   localparam logic [2:0] ST_RUN1   = 3'd2;
   localparam logic [2:0] ST_RUN2   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]   state_ff, state_in;
   word_type     seed_ff, seed_in;
   word_type     max_ff, max_in;
   word_type     cap;
   logic         xf_load, xf_done;
   table_type    truth;
   run_cmd_type  run_cmd;
   run_stat_type run_stat;

   // per-item results
   word_type p1_ff, p1_in, p2_ff, p2_in;
   logic     r1_ff, r1_in, r2_ff, r2_in, tried_ff, tried_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_p1_ff, rsp_p1_in, rsp_p2_ff, rsp_p2_in;
   logic     rsp_r1_ff, rsp_r1_in, rsp_r2_ff, rsp_r2_in, rsp_tr_ff, rsp_tr_in;
   logic     rsp_free;

   assign cap = (max_ff == '0) ? word_type'(1) : max_ff;

   // configuration writes
   assign csr_ch.ready = 1'b1;
   always_comb begin
      seed_in = seed_ff;
      max_in  = max_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SEED_VALUE: seed_in = csr_ch.data;
            CSR_MAX_STEPS:  max_in  = csr_ch.data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign xf_load      = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   nlfsr_anf_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .load     (xf_load),
      .anf_low  (req_ch.anf_low),
      .anf_high (req_ch.anf_high),
      .done     (xf_done),
      .truth    (truth)
   );

   nlfsr_step_unit u_step (
      .clock (clock),
      .reset (reset),
      .cmd   (run_cmd),
      .seed  (seed_ff),
      .cap   (cap),
      .truth (truth),
      .stat  (run_stat)
   );

   // sequencer
   always_comb begin
      state_in         = state_ff;
      run_cmd.start    = 1'b0;
      run_cmd.tap_alt  = 1'b0;
      p1_in            = p1_ff;
      r1_in            = r1_ff;
      tried_in         = tried_ff;
      p2_in            = p2_ff;
      r2_in            = r2_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_p1_in        = rsp_p1_ff;
      rsp_r1_in        = rsp_r1_ff;
      rsp_tr_in        = rsp_tr_ff;
      rsp_p2_in        = rsp_p2_ff;
      rsp_r2_in        = rsp_r2_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_XFORM;
            end
         end
         ST_XFORM: begin
            if (xf_done) begin
               run_cmd.start = 1'b1;
               state_in      = ST_RUN1;
            end
         end
         ST_RUN1: begin
            if (run_stat.done) begin
               p1_in    = run_stat.period;
               r1_in    = run_stat.returned;
               tried_in = (run_stat.period == cap);
               p2_in    = '0;
               r2_in    = 1'b0;
               if (run_stat.period == cap) begin
                  run_cmd.start   = 1'b1;
                  run_cmd.tap_alt = 1'b1;
                  state_in        = ST_RUN2;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_RUN2: begin
            if (run_stat.done) begin
               p2_in    = run_stat.period;
               r2_in    = run_stat.returned;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_p1_in    = p1_ff;
               rsp_r1_in    = r1_ff;
               rsp_tr_in    = tried_ff;
               rsp_p2_in    = p2_ff;
               rsp_r2_in    = r2_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         max_ff       <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_ff     <= p1_in;
      r1_ff     <= r1_in;
      tried_ff  <= tried_in;
      p2_ff     <= p2_in;
      r2_ff     <= r2_in;
      rsp_p1_ff <= rsp_p1_in;
      rsp_r1_ff <= rsp_r1_in;
      rsp_tr_ff <= rsp_tr_in;
      rsp_p2_ff <= rsp_p2_in;
      rsp_r2_ff <= rsp_r2_in;
   end

   // result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.first_period    = rsp_p1_ff;
   assign rsp_ch.first_returned  = rsp_r1_ff;
   assign rsp_ch.second_tried    = rsp_tr_ff;
   assign rsp_ch.second_period   = rsp_p2_ff;
   assign rsp_ch.second_returned = rsp_r2_ff;

endmodule

`default_nettype wire

/* hw/rtl/nlfsr_checker.sv */
// nlfsr_checker: port-level assertions on the nlfsr period tester
// depends on nlfsr_pkg; bound to nlfsr_period_tester at the end of this file
`default_nettype none

module nlfsr_checker import nlfsr_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_ready,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire word_type first_period,
   input wire logic     first_returned,
   input wire logic     second_tried,
   input wire word_type second_period,
   input wire logic     second_returned
);

   // an accepted item keeps the block busy for the transform at least
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req ready right after a transfer");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(first_period)
         && $stable(second_period) && $stable(second_tried)))
      else $error("stalled result changed");

   // no second run means empty second fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !second_tried) |-> (second_period == '0 && !second_returned))
      else $error("second fields set without a second run");

   // a first run that never returned hit the cap, so the second run was tried
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !first_returned) |-> second_tried)
      else $error("first run missed the seed but no second run");

   // periods are never zero; checked on results with a second run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && second_tried) |-> (first_period != '0 && second_period != '0))
      else $error("zero period reported");

endmodule

bind nlfsr_period_tester nlfsr_checker u_nlfsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .first_period    (rsp_ch.first_period),
   .first_returned  (rsp_ch.first_returned),
   .second_tried    (rsp_ch.second_tried),
   .second_period   (rsp_ch.second_period),
   .second_returned (rsp_ch.second_returned)
);

`default_nettype wire
